// File: rtl/packet_timestamp_normalizer_unit_defines.svh
// Assertion helpers shared by the RTL files.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef PACKET_TIMESTAMP_NORMALIZER_UNIT_DEFINES_SVH
`define PACKET_TIMESTAMP_NORMALIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PTN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTN_ASSERT_IMPL(lbl, ante, cons, msg)
`define PTN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/ptn_pkg.sv
`default_nettype none

package ptn_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned JOBQ_DEPTH = 2;
  // two quotient bits per step, 64 quotient bits
  localparam int unsigned DIV_STEPS  = 32;
  localparam logic [62:0] MAX63      = {63{1'b1}};

  typedef struct packed {
    logic [7:0]  video_in_id;
    logic [8:0]  audio_in_id;
    logic [7:0]  video_out_id;
    logic [7:0]  audio_out_id;
    logic [31:0] video_mul;
    logic [31:0] video_div;
    logic [31:0] audio_mul;
    logic [31:0] audio_div;
  } cfg_t;

  typedef struct packed {
    logic        clr;
    logic        is_video;
    logic        has_pts;
    logic        has_dts;
    logic [63:0] pts_off;
    logic [63:0] dts_off;
    logic [31:0] dur;
    logic [31:0] mul;
    logic [31:0] div;
    logic [7:0]  oid;
  } job_t;

  typedef struct packed {
    logic        start;
    logic        lim32;
    logic [63:0] v;
    logic [31:0] mul;
    logic [31:0] div;
  } rs_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } rs_rsp_t;

endpackage

`default_nettype wire

// File: rtl/ptn_front.sv
`default_nettype none

module ptn_front #(
  parameter int unsigned TS_BITS = 64,
  parameter int unsigned ID_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_stream_id,
  input  wire logic               in_pts_present,
  input  wire logic [63:0]        in_pts_in,
  input  wire logic               in_dts_present,
  input  wire logic [63:0]        in_dts_in,
  input  wire logic [31:0]        in_dur_in,
  input  ptn_pkg::cfg_t           cfg,
  input  wire logic               q_full,
  output logic                    q_wr,
  output ptn_pkg::job_t           q_wdata
);
  import ptn_pkg::*;

  localparam int unsigned CMP_W = (ID_BITS < 8) ? ID_BITS : 8;

  logic        va_r, va_nxt, aa_r, aa_nxt;
  logic [63:0] vorg_r, vorg_nxt, aorg_r, aorg_nxt;
  logic [63:0] pts_x, dts_x, anc_val, origin;
  logic        accept, vid_hit, aud_hit;

  assign accept = in_push && !q_full;

  // timestamps are signed TS_BITS-bit values, upper bits ignored
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      pts_x[i] = (i < TS_BITS) ? in_pts_in[i] : in_pts_in[TS_BITS-1];
      dts_x[i] = (i < TS_BITS) ? in_dts_in[i] : in_dts_in[TS_BITS-1];
    end
  end

  assign anc_val = in_dts_present ? dts_x : (in_pts_present ? pts_x : 64'd0);
  assign vid_hit = in_stream_id[CMP_W-1:0] == cfg.video_in_id[CMP_W-1:0];
  assign aud_hit = !cfg.audio_in_id[8] &&
                   (in_stream_id[CMP_W-1:0] == cfg.audio_in_id[CMP_W-1:0]);
  // an anchoring word uses its own anchor value
  assign origin  = vid_hit ? (va_r ? vorg_r : anc_val) : (aa_r ? aorg_r : anc_val);

  always_comb begin
    va_nxt   = va_r;
    aa_nxt   = aa_r;
    vorg_nxt = vorg_r;
    aorg_nxt = aorg_r;
    q_wr     = 1'b0;

    q_wdata          = '0;
    q_wdata.is_video = vid_hit;
    q_wdata.has_pts  = in_pts_present;
    q_wdata.has_dts  = in_dts_present;
    q_wdata.pts_off  = ($signed(pts_x) > $signed(origin)) ? pts_x - origin : 64'd0;
    q_wdata.dts_off  = ($signed(dts_x) > $signed(origin)) ? dts_x - origin : 64'd0;
    q_wdata.dur      = in_dur_in;
    q_wdata.mul      = vid_hit ? cfg.video_mul : cfg.audio_mul;
    q_wdata.div      = vid_hit ? cfg.video_div : cfg.audio_div;
    q_wdata.oid      = vid_hit ? cfg.video_out_id : cfg.audio_out_id;

    priority if (!accept) begin
      q_wr = 1'b0;
    end else if (in_op) begin
      va_nxt      = 1'b0;
      aa_nxt      = 1'b0;
      q_wdata.clr = 1'b1;
      q_wr        = 1'b1;
    end else if (vid_hit) begin
      if (!va_r) begin
        va_nxt   = 1'b1;
        vorg_nxt = anc_val;
      end
      q_wr = 1'b1;
    end else if (aud_hit && va_r) begin
      if (!aa_r) begin
        aa_nxt   = 1'b1;
        aorg_nxt = anc_val;
      end
      q_wr = 1'b1;
    end else begin
      q_wr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      aa_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      aa_r <= aa_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vorg_r <= vorg_nxt;
    aorg_r <= aorg_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/ptn_fifo.sv
`default_nettype none
`include "packet_timestamp_normalizer_unit_defines.svh"

module ptn_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  ptn_pkg::job_t wdata,
  input  wire logic     rd,
  output ptn_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);
  import ptn_pkg::*;

  localparam int unsigned PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             slot_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_W'(JOBQ_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

  `PTN_ASSERT_IMPL(a_no_overflow, wr, !full, "job queue written while full")
  `PTN_ASSERT_IMPL(a_no_underflow, rd, !empty, "job queue read while empty")
  `PTN_ASSERT_NEXT(a_count_up, wr && !rd, cnt_r == $past(cnt_r) + 1'b1, "job count lost")

endmodule

`default_nettype wire

// File: rtl/ptn_rescale.sv
`default_nettype none

module ptn_rescale (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  ptn_pkg::rs_req_t req,
  output ptn_pkg::rs_rsp_t rsp
);
  import ptn_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] RS_IDLE = 3'd0;
  localparam logic [2:0] RS_P0   = 3'd1;
  localparam logic [2:0] RS_P1   = 3'd2;
  localparam logic [2:0] RS_SUM  = 3'd3;
  localparam logic [2:0] RS_DIV  = 3'd4;
  localparam logic [2:0] RS_FIN  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [63:0]      v_r, v_nxt, p0_r, p0_nxt, p1_r, p1_nxt;
  logic [63:0]      quo_r, quo_nxt, q_r, q_nxt;
  logic [31:0]      mul_r, mul_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic             lim32_r, lim32_nxt, ovf_r, ovf_nxt;

  logic [31:0] mul_a;
  logic [63:0] prod, lim;
  logic [95:0] sum;
  logic [32:0] r2a, r2b, ra, rb;
  logic        gea, geb;

  // one 32x32 multiplier, low half then high half
  assign mul_a = (st_r == RS_P0) ? v_r[31:0] : v_r[63:32];
  assign prod  = mul_a * mul_r;

  // product plus half the divisor for round-half-up
  assign sum = {p1_r, 32'd0} + {32'd0, p0_r} + {65'd0, d_r[31:1]};

  // two restoring steps; the remainder stays below the divisor
  always_comb begin
    r2a = {rem_r, quo_r[63]};
    gea = r2a >= {1'b0, d_r};
    ra  = gea ? r2a - {1'b0, d_r} : r2a;
    r2b = {ra[31:0], quo_r[62]};
    geb = r2b >= {1'b0, d_r};
    rb  = geb ? r2b - {1'b0, d_r} : r2b;
  end

  assign lim = lim32_r ? {32'd0, 32'hFFFF_FFFF} : {1'b0, MAX63};

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    v_nxt     = v_r;
    mul_nxt   = mul_r;
    d_nxt     = d_r;
    lim32_nxt = lim32_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    q_nxt     = q_r;
    unique case (st_r)
      RS_IDLE: begin
        if (req.start) begin
          v_nxt     = req.v;
          mul_nxt   = req.mul;
          d_nxt     = (req.div == '0) ? 32'd1 : req.div;
          lim32_nxt = req.lim32;
          st_nxt    = RS_P0;
        end
      end
      RS_P0: begin
        p0_nxt = prod;
        st_nxt = RS_P1;
      end
      RS_P1: begin
        p1_nxt = prod;
        st_nxt = RS_SUM;
      end
      RS_SUM: begin
        // quotient needs more than 64 bits when the top word reaches the divisor
        ovf_nxt = sum[95:64] >= d_r;
        rem_nxt = sum[95:64];
        quo_nxt = sum[63:0];
        cnt_nxt = '0;
        st_nxt  = RS_DIV;
      end
      RS_DIV: begin
        rem_nxt = rb[31:0];
        quo_nxt = {quo_r[61:0], gea, geb};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          st_nxt = RS_FIN;
        end
      end
      RS_FIN: begin
        q_nxt    = (ovf_r || (quo_r > lim)) ? lim : quo_r;
        done_nxt = 1'b1;
        st_nxt   = RS_IDLE;
      end
      default: begin
        st_nxt = RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= RS_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    mul_r   <= mul_nxt;
    d_r     <= d_nxt;
    lim32_r <= lim32_nxt;
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    ovf_r   <= ovf_nxt;
    q_r     <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

`default_nettype wire

// File: rtl/ptn_back.sv
`default_nettype none
`include "packet_timestamp_normalizer_unit_defines.svh"

module ptn_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  ptn_pkg::job_t    q_rdata,
  output logic             q_rd,
  output ptn_pkg::rs_req_t rs_req,
  input  ptn_pkg::rs_rsp_t rs_rsp,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic [7:0]       out_out_id,
  output logic             out_pts_ok,
  output logic [62:0]      out_pts_out,
  output logic             out_dts_ok,
  output logic [62:0]      out_dts_out,
  output logic [31:0]      out_dur_out,
  output logic [62:0]      out_video_span
);
  import ptn_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LAUNCH = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;
  localparam logic [2:0] ST_TRACK  = 3'd5;
  localparam logic [2:0] ST_SPAN   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam logic [1:0] SEL_PTS = 2'd0;
  localparam logic [1:0] SEL_DTS = 2'd1;
  localparam logic [1:0] SEL_DUR = 2'd2;

  logic [2:0]  st_r, st_nxt;
  logic [1:0]  sel_r, sel_nxt;
  job_t        job_r, job_nxt;
  logic [62:0] pts_r, pts_nxt, dts_r, dts_nxt, span_r, span_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic        bump_r, bump_nxt;
  logic [63:0] shift_r, shift_nxt;

  logic        vdts_v_r, vdts_v_nxt, adts_v_r, adts_v_nxt;
  logic        fvp_v_r, fvp_v_nxt, lvp_v_r, lvp_v_nxt;
  logic [62:0] vdts_r, vdts_nxt, adts_r, adts_nxt, fvp_r, fvp_nxt, lvp_r, lvp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  o_id_r, o_id_nxt;
  logic        o_pok_r, o_pok_nxt, o_dok_r, o_dok_nxt;
  logic [62:0] o_pts_r, o_pts_nxt, o_dts_r, o_dts_nxt, o_span_r, o_span_nxt;
  logic [31:0] o_dur_r, o_dur_nxt;

  logic        need, lim32, cur_last_v;
  logic [63:0] operand, pts_sum;
  logic [62:0] cur_last;

  assign cur_last_v = job_r.is_video ? vdts_v_r : adts_v_r;
  assign cur_last   = job_r.is_video ? vdts_r : adts_r;
  assign pts_sum    = {1'b0, pts_r} + shift_r;

  always_comb begin
    need    = 1'b0;
    operand = '0;
    lim32   = 1'b0;
    unique case (sel_r)
      SEL_PTS: begin
        need    = job_r.has_pts;
        operand = job_r.pts_off;
      end
      SEL_DTS: begin
        need    = job_r.has_dts;
        operand = job_r.dts_off;
      end
      SEL_DUR: begin
        need    = job_r.dur != '0;
        operand = {32'd0, job_r.dur};
        lim32   = 1'b1;
      end
      default: begin
        need = 1'b0;
      end
    endcase
  end

  assign rs_req.start = (st_r == ST_LAUNCH) && need;
  assign rs_req.lim32 = lim32;
  assign rs_req.v     = operand;
  assign rs_req.mul   = job_r.mul;
  assign rs_req.div   = job_r.div;

  always_comb begin
    st_nxt        = st_r;
    sel_nxt       = sel_r;
    job_nxt       = job_r;
    pts_nxt       = pts_r;
    dts_nxt       = dts_r;
    dur_nxt       = dur_r;
    span_nxt      = span_r;
    bump_nxt      = bump_r;
    shift_nxt     = shift_r;
    vdts_v_nxt    = vdts_v_r;
    adts_v_nxt    = adts_v_r;
    fvp_v_nxt     = fvp_v_r;
    lvp_v_nxt     = lvp_v_r;
    vdts_nxt      = vdts_r;
    adts_nxt      = adts_r;
    fvp_nxt       = fvp_r;
    lvp_nxt       = lvp_r;
    out_valid_nxt = out_valid_r;
    o_id_nxt      = o_id_r;
    o_pok_nxt     = o_pok_r;
    o_dok_nxt     = o_dok_r;
    o_pts_nxt     = o_pts_r;
    o_dts_nxt     = o_dts_r;
    o_dur_nxt     = o_dur_r;
    o_span_nxt    = o_span_r;
    q_rd          = 1'b0;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd    = 1'b1;
          job_nxt = q_rdata;
          if (q_rdata.clr) begin
            vdts_v_nxt = 1'b0;
            adts_v_nxt = 1'b0;
            fvp_v_nxt  = 1'b0;
            lvp_v_nxt  = 1'b0;
          end else begin
            sel_nxt = SEL_PTS;
            st_nxt  = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        if (need) begin
          st_nxt = ST_WAIT;
        end else begin
          // absent field reads as zero
          if (sel_r == SEL_PTS) pts_nxt = '0;
          if (sel_r == SEL_DTS) dts_nxt = '0;
          if (sel_r == SEL_DUR) dur_nxt = '0;
          if (sel_r == SEL_DUR) begin
            st_nxt = ST_SHIFT;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (rs_rsp.done) begin
          if (sel_r == SEL_PTS) pts_nxt = rs_rsp.q[62:0];
          if (sel_r == SEL_DTS) dts_nxt = rs_rsp.q[62:0];
          if (sel_r == SEL_DUR) dur_nxt = rs_rsp.q[31:0];
          if (sel_r == SEL_DUR) begin
            st_nxt = ST_SHIFT;
          end else begin
            sel_nxt = sel_r + 1'b1;
            st_nxt  = ST_LAUNCH;
          end
        end
      end
      ST_SHIFT: begin
        bump_nxt  = job_r.has_dts && cur_last_v && (dts_r <= cur_last);
        shift_nxt = {1'b0, cur_last} - {1'b0, dts_r} + 64'd1;
        st_nxt    = ST_APPLY;
      end
      ST_APPLY: begin
        if (bump_r) begin
          // dts + shift is last + 1, saturated
          dts_nxt = (cur_last == MAX63) ? MAX63 : cur_last + 63'd1;
          if (job_r.has_pts) begin
            pts_nxt = pts_sum[63] ? MAX63 : pts_sum[62:0];
          end
        end
        st_nxt = ST_TRACK;
      end
      ST_TRACK: begin
        if (job_r.has_dts) begin
          if (job_r.is_video) begin
            vdts_v_nxt = 1'b1;
            vdts_nxt   = dts_r;
          end else begin
            adts_v_nxt = 1'b1;
            adts_nxt   = dts_r;
          end
        end
        if (job_r.is_video && job_r.has_pts) begin
          if (!fvp_v_r) begin
            fvp_v_nxt = 1'b1;
            fvp_nxt   = pts_r;
          end
          lvp_v_nxt = 1'b1;
          lvp_nxt   = pts_r;
        end
        st_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        span_nxt = (fvp_v_r && lvp_v_r && (lvp_r >= fvp_r)) ? lvp_r - fvp_r : '0;
        st_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          o_id_nxt      = job_r.oid;
          o_pok_nxt     = job_r.has_pts;
          o_dok_nxt     = job_r.has_dts;
          o_pts_nxt     = pts_r;
          o_dts_nxt     = dts_r;
          o_dur_nxt     = dur_r;
          o_span_nxt    = span_r;
          st_nxt        = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sel_r       <= SEL_PTS;
      vdts_v_r    <= 1'b0;
      adts_v_r    <= 1'b0;
      fvp_v_r     <= 1'b0;
      lvp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sel_r       <= sel_nxt;
      vdts_v_r    <= vdts_v_nxt;
      adts_v_r    <= adts_v_nxt;
      fvp_v_r     <= fvp_v_nxt;
      lvp_v_r     <= lvp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    pts_r    <= pts_nxt;
    dts_r    <= dts_nxt;
    dur_r    <= dur_nxt;
    span_r   <= span_nxt;
    bump_r   <= bump_nxt;
    shift_r  <= shift_nxt;
    vdts_r   <= vdts_nxt;
    adts_r   <= adts_nxt;
    fvp_r    <= fvp_nxt;
    lvp_r    <= lvp_nxt;
    o_id_r   <= o_id_nxt;
    o_pok_r  <= o_pok_nxt;
    o_dok_r  <= o_dok_nxt;
    o_pts_r  <= o_pts_nxt;
    o_dts_r  <= o_dts_nxt;
    o_dur_r  <= o_dur_nxt;
    o_span_r <= o_span_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_out_id     = o_id_r;
  assign out_pts_ok     = o_pok_r;
  assign out_pts_out    = o_pts_r;
  assign out_dts_ok     = o_dok_r;
  assign out_dts_out    = o_dts_r;
  assign out_dur_out    = o_dur_r;
  assign out_video_span = o_span_r;

  `PTN_ASSERT_IMPL(a_done_in_wait, rs_rsp.done, st_r == ST_WAIT, "rescale result unexpected")
  `PTN_ASSERT_NEXT(a_clr_trackers, (st_r == ST_IDLE) && q_rd && q_rdata.clr, !vdts_v_r && !adts_v_r && !fvp_v_r && !lvp_v_r, "segment start left a tracker set")
  `PTN_ASSERT_IMPL(a_dts_rises, (st_r == ST_TRACK) && job_r.has_dts && cur_last_v, (dts_r > cur_last) || (dts_r == MAX63), "dts not increasing")

endmodule

`default_nettype wire

// File: rtl/packet_timestamp_normalizer_unit.sv
`default_nettype none
// Channel   Handshake                 Word
// input     push / full               in_op .. in_dur_in (one packet or segment start)
// result    pop / empty               out_out_id .. out_video_span
// config    psel/penable/pwrite/pready  8 regs at paddr 4*i, 32-bit pwdata/prdata
//
// Packet time is set by the shared rescale unit, used once per rescaled field (pts,
// dts, nonzero duration): one 32x32 multiplier, then a 64-bit quotient at two bits
// per cycle.
// Reset (rst_n low, synchronous) clears anchors, trackers, queues and registers.
// A 2-word job queue lets input accept while the back end works or the result waits.
module packet_timestamp_normalizer_unit #(
  parameter int unsigned TS_BITS = 64,
  parameter int unsigned ID_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_stream_id,
  input  wire logic                          in_pts_present,
  input  wire logic [63:0]                   in_pts_in,
  input  wire logic                          in_dts_present,
  input  wire logic [63:0]                   in_dts_in,
  input  wire logic [31:0]                   in_dur_in,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [7:0]                         out_out_id,
  output logic                               out_pts_ok,
  output logic [62:0]                        out_pts_out,
  output logic                               out_dts_ok,
  output logic [62:0]                        out_dts_out,
  output logic [31:0]                        out_dur_out,
  output logic [62:0]                        out_video_span,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ptn_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ptn_pkg::*;

  localparam logic [2:0] REG_VIDEO_IN_ID  = 3'd0;
  localparam logic [2:0] REG_AUDIO_IN_ID  = 3'd1;
  localparam logic [2:0] REG_VIDEO_OUT_ID = 3'd2;
  localparam logic [2:0] REG_AUDIO_OUT_ID = 3'd3;
  localparam logic [2:0] REG_VIDEO_MUL    = 3'd4;
  localparam logic [2:0] REG_VIDEO_DIV    = 3'd5;
  localparam logic [2:0] REG_AUDIO_MUL    = 3'd6;
  localparam logic [2:0] REG_AUDIO_DIV    = 3'd7;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  job_t    q_wdata, q_rdata;
  logic    q_wr, q_rd, q_full, q_empty;
  rs_req_t rs_req;
  rs_rsp_t rs_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_VIDEO_IN_ID:  cfg_nxt.video_in_id  = pwdata[7:0];
        REG_AUDIO_IN_ID:  cfg_nxt.audio_in_id  = pwdata[8:0];
        REG_VIDEO_OUT_ID: cfg_nxt.video_out_id = pwdata[7:0];
        REG_AUDIO_OUT_ID: cfg_nxt.audio_out_id = pwdata[7:0];
        REG_VIDEO_MUL:    cfg_nxt.video_mul    = pwdata;
        REG_VIDEO_DIV:    cfg_nxt.video_div    = pwdata;
        REG_AUDIO_MUL:    cfg_nxt.audio_mul    = pwdata;
        REG_AUDIO_DIV:    cfg_nxt.audio_div    = pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VIDEO_IN_ID:  prdata = {24'd0, cfg_r.video_in_id};
      REG_AUDIO_IN_ID:  prdata = {23'd0, cfg_r.audio_in_id};
      REG_VIDEO_OUT_ID: prdata = {24'd0, cfg_r.video_out_id};
      REG_AUDIO_OUT_ID: prdata = {24'd0, cfg_r.audio_out_id};
      REG_VIDEO_MUL:    prdata = cfg_r.video_mul;
      REG_VIDEO_DIV:    prdata = cfg_r.video_div;
      REG_AUDIO_MUL:    prdata = cfg_r.audio_mul;
      REG_AUDIO_DIV:    prdata = cfg_r.audio_div;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.video_in_id  <= 8'd0;
      cfg_r.audio_in_id  <= 9'h1FF;  // no audio
      cfg_r.video_out_id <= 8'd0;
      cfg_r.audio_out_id <= 8'd1;
      cfg_r.video_mul    <= 32'd1;
      cfg_r.video_div    <= 32'd1;
      cfg_r.audio_mul    <= 32'd1;
      cfg_r.audio_div    <= 32'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full = q_full;

  ptn_front #(
    .TS_BITS (TS_BITS),
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (push),
    .in_op          (in_op),
    .in_stream_id   (in_stream_id),
    .in_pts_present (in_pts_present),
    .in_pts_in      (in_pts_in),
    .in_dts_present (in_dts_present),
    .in_dts_in      (in_dts_in),
    .in_dur_in      (in_dur_in),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_wdata        (q_wdata)
  );

  ptn_fifo u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ptn_rescale u_rescale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rs_req),
    .rsp   (rs_rsp)
  );

  ptn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .rs_req         (rs_req),
    .rs_rsp         (rs_rsp),
    .out_pop        (pop),
    .out_empty      (empty),
    .out_out_id     (out_out_id),
    .out_pts_ok     (out_pts_ok),
    .out_pts_out    (out_pts_out),
    .out_dts_ok     (out_dts_ok),
    .out_dts_out    (out_dts_out),
    .out_dur_out    (out_dur_out),
    .out_video_span (out_video_span)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int          ADDR_W        = ptn_pkg::CFG_ADDR_W;
  localparam logic [63:0] TS_MAX        = {1'b0, ptn_pkg::MAX63};
  localparam logic        OP_PACKET     = 1'b0;
  localparam logic        OP_SEGMENT    = 1'b1;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          CYCLE_LIMIT   = 1500000;
  localparam int          PHASE_WORDS   = 250;

  typedef enum int unsigned {
    REG_VIDEO_IN_ID, REG_AUDIO_IN_ID, REG_VIDEO_OUT_ID, REG_AUDIO_OUT_ID,
    REG_VIDEO_MUL, REG_VIDEO_DIV, REG_AUDIO_MUL, REG_AUDIO_DIV
  } cfg_reg_e;

  typedef enum int unsigned {ROW_WORD, ROW_FIXED, ROW_CFG} row_kind_e;

  typedef struct {
    logic        op;
    logic [7:0]  sid;
    logic        pts_p;
    logic [63:0] pts;
    logic        dts_p;
    logic [63:0] dts;
    logic [31:0] dur;
  } pkt_t;

  typedef struct {
    logic [7:0]  oid;
    logic        pts_ok;
    logic [62:0] pts;
    logic        dts_ok;
    logic [62:0] dts;
    logic [31:0] dur;
    logic [62:0] span;
  } norm_t;

  typedef struct {
    row_kind_e   kind;
    pkt_t        word;
    norm_t       res;
    cfg_reg_e    ridx;
    logic [31:0] rval;
  } row_t;

  typedef struct {
    bit          valid;
    logic [63:0] value;
  } track_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_op = 1'b0;
  logic [7:0]  in_stream_id = '0;
  logic        in_pts_present = 1'b0;
  logic [63:0] in_pts_in = '0;
  logic        in_dts_present = 1'b0;
  logic [63:0] in_dts_in = '0;
  logic [31:0] in_dur_in = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  out_out_id;
  logic        out_pts_ok;
  logic [62:0] out_pts_out;
  logic        out_dts_ok;
  logic [62:0] out_dts_out;
  logic [31:0] out_dur_out;
  logic [62:0] out_video_span;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk = ~clk;

  packet_timestamp_normalizer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_op(in_op), .in_stream_id(in_stream_id),
    .in_pts_present(in_pts_present), .in_pts_in(in_pts_in),
    .in_dts_present(in_dts_present), .in_dts_in(in_dts_in), .in_dur_in(in_dur_in),
    .pop(pop), .empty(empty),
    .out_out_id(out_out_id), .out_pts_ok(out_pts_ok), .out_pts_out(out_pts_out),
    .out_dts_ok(out_dts_ok), .out_dts_out(out_dts_out), .out_dur_out(out_dur_out),
    .out_video_span(out_video_span),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------- normalizer predictor ----------------
  ptn_pkg::cfg_t cfg;
  bit            v_anch, a_anch;
  logic [63:0]   v_org, a_org;
  track_t        v_prev, a_prev, first_vpts, latest_vpts;

  norm_t pending_stamps[$];
  int    bad_cnt = 0;
  bit    idle_on = 1'b1;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    stall_left = 0;

  function automatic void clear_segment();
    v_anch = 0;
    a_anch = 0;
    v_org = '0;
    a_org = '0;
    v_prev = '{0, 64'd0};
    a_prev = '{0, 64'd0};
    first_vpts = '{0, 64'd0};
    latest_vpts = '{0, 64'd0};
  endfunction

  function automatic logic [63:0] clamp_off(logic [63:0] x, logic [63:0] org);
    if ($signed(x) <= $signed(org)) return 64'd0;
    return x - org;
  endfunction

  // round half up of v*mul/div, saturated at lim
  function automatic logic [63:0] scale_ts(logic [63:0] v, logic [31:0] mul,
                                           logic [31:0] dv, logic [63:0] lim);
    logic [127:0] d;
    logic [127:0] q;
    d = (dv == 32'd0) ? 128'd1 : {96'd0, dv};
    q = ({64'd0, v} * {96'd0, mul} + (d >> 1)) / d;
    return (q > {64'd0, lim}) ? lim : q[63:0];
  endfunction

  function automatic logic [63:0] anchor_of(pkt_t w);
    return w.dts_p ? w.dts : (w.pts_p ? w.pts : 64'd0);
  endfunction

  function automatic logic [63:0] sat63(logic [63:0] s);
    return (s > TS_MAX) ? TS_MAX : s;
  endfunction

  function automatic bit normalize_word(pkt_t w, output norm_t r);
    bit          vid;
    logic [31:0] mul, dv;
    logic [7:0]  oid;
    logic [63:0] org, pts, dts, dur_o, span, shift;
    track_t      prev;
    r = '{8'd0, 1'b0, 63'd0, 1'b0, 63'd0, 32'd0, 63'd0};
    if (w.op == OP_SEGMENT) begin
      clear_segment();
      return 0;
    end
    if (w.sid == cfg.video_in_id) begin
      vid = 1;
    end else if (!cfg.audio_in_id[8] && w.sid == cfg.audio_in_id[7:0]) begin
      vid = 0;
    end else begin
      return 0;
    end
    if (!v_anch) begin
      if (!vid) return 0;
      v_org = anchor_of(w);
      v_anch = 1;
    end
    if (!vid && !a_anch) begin
      a_org = anchor_of(w);
      a_anch = 1;
    end
    org  = vid ? v_org : a_org;
    mul  = vid ? cfg.video_mul : cfg.audio_mul;
    dv   = vid ? cfg.video_div : cfg.audio_div;
    oid  = vid ? cfg.video_out_id : cfg.audio_out_id;
    prev = vid ? v_prev : a_prev;
    pts   = w.pts_p ? scale_ts(clamp_off(w.pts, org), mul, dv, TS_MAX) : 64'd0;
    dts   = w.dts_p ? scale_ts(clamp_off(w.dts, org), mul, dv, TS_MAX) : 64'd0;
    dur_o = (w.dur != 0) ? scale_ts({32'd0, w.dur}, mul, dv, 64'hFFFF_FFFF) : 64'd0;
    if (w.dts_p) begin
      if (prev.valid && dts <= prev.value) begin
        shift = prev.value - dts + 64'd1;
        dts = sat63(dts + shift);
        if (w.pts_p) pts = sat63(pts + shift);
      end
      prev = '{1, dts};
    end
    if (vid) v_prev = prev;
    else a_prev = prev;
    if (vid && w.pts_p) begin
      if (!first_vpts.valid) first_vpts = '{1, pts};
      latest_vpts = '{1, pts};
    end
    span = 64'd0;
    if (first_vpts.valid && latest_vpts.valid && latest_vpts.value >= first_vpts.value)
      span = latest_vpts.value - first_vpts.value;
    r = '{oid, w.pts_p, pts[62:0], w.dts_p, dts[62:0], dur_o[31:0], span[62:0]};
    return 1;
  endfunction

  // ---------------- table helpers ----------------
  function automatic pkt_t mk_word(logic op, logic [7:0] sid, logic pp, logic [63:0] pts,
                                   logic dp, logic [63:0] dts, logic [31:0] dur);
    return '{op, sid, pp, pts, dp, dts, dur};
  endfunction

  function automatic norm_t mk_norm(logic [7:0] oid, logic pok, logic [62:0] pts,
                                    logic dok, logic [62:0] dts, logic [31:0] dur,
                                    logic [62:0] span);
    return '{oid, pok, pts, dok, dts, dur, span};
  endfunction

  function automatic row_t word_row(pkt_t w);
    return '{ROW_WORD, w, mk_norm(0, 0, 0, 0, 0, 0, 0), REG_VIDEO_IN_ID, 32'd0};
  endfunction

  function automatic row_t fixed_row(pkt_t w, norm_t r);
    return '{ROW_FIXED, w, r, REG_VIDEO_IN_ID, 32'd0};
  endfunction

  function automatic row_t cfg_row(cfg_reg_e idx, logic [31:0] v);
    return '{ROW_CFG, mk_word(0, 0, 0, 0, 0, 0, 0), mk_norm(0, 0, 0, 0, 0, 0, 0), idx, v};
  endfunction

  function automatic logic [31:0] pick_scale(bit is_div);
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 1000);
      3: return 32'd90000;
      4: return 32'd1001;
      5: return $urandom | 32'd1;
      6: return is_div ? 32'd0 : 32'd48000;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic reg_write(input cfg_reg_e idx, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= v;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_VIDEO_IN_ID:  cfg.video_in_id  = v[7:0];
      REG_AUDIO_IN_ID:  cfg.audio_in_id  = v[8:0];
      REG_VIDEO_OUT_ID: cfg.video_out_id = v[7:0];
      REG_AUDIO_OUT_ID: cfg.audio_out_id = v[7:0];
      REG_VIDEO_MUL:    cfg.video_mul    = v;
      REG_VIDEO_DIV:    cfg.video_div    = v;
      REG_AUDIO_MUL:    cfg.audio_mul    = v;
      default:          cfg.audio_div    = v;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // push stays high on return so back-to-back words need no extra edge
  task automatic send_word(input pkt_t w, input bit fixed, input norm_t fres,
                           output bit got);
    norm_t r;
    @(negedge clk);
    in_op          <= w.op;
    in_stream_id   <= w.sid;
    in_pts_present <= w.pts_p;
    in_pts_in      <= w.pts;
    in_dts_present <= w.dts_p;
    in_dts_in      <= w.dts;
    in_dur_in      <= w.dur;
    push           <= 1'b1;
    do @(posedge clk); while (full);
    got = normalize_word(w, r);
    if (fixed) begin
      r = fres;
      got = 1;
    end
    if (got) pending_stamps.push_back(r);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk) push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk) push <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    norm_t seen, want;
    if (rst_n && pop && !empty) begin
      seen = '{out_out_id, out_pts_ok, out_pts_out, out_dts_ok, out_dts_out,
               out_dur_out, out_video_span};
      if (pending_stamps.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected word: id=%0d pts=%0b/%h dts=%0b/%h dur=%h span=%h",
                   seen.oid, seen.pts_ok, seen.pts, seen.dts_ok, seen.dts, seen.dur,
                   seen.span);
      end else begin
        want = pending_stamps.pop_front();
        if (seen.oid !== want.oid || seen.pts_ok !== want.pts_ok ||
            seen.pts !== want.pts || seen.dts_ok !== want.dts_ok ||
            seen.dts !== want.dts || seen.dur !== want.dur || seen.span !== want.span) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display({"mismatch: exp id=%0d pts=%0b/%h dts=%0b/%h dur=%h span=%h",
                      " got id=%0d pts=%0b/%h dts=%0b/%h dur=%h span=%h"},
                     want.oid, want.pts_ok, want.pts, want.dts_ok, want.dts, want.dur,
                     want.span, seen.oid, seen.pts_ok, seen.pts, seen.dts_ok, seen.dts,
                     seen.dur, seen.span);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- stimulus ----------------
  initial begin
    row_t        rows[$];
    pkt_t        w;
    norm_t       none;
    bit          got;
    int          done_cnt, n;
    logic [7:0]  vid;
    logic [8:0]  aid;
    logic [63:0] ts_base;

    none = mk_norm(0, 0, 0, 0, 0, 0, 0);
    cfg.video_in_id  = 8'd0;
    cfg.audio_in_id  = 9'h1FF;
    cfg.video_out_id = 8'd0;
    cfg.audio_out_id = 8'd1;
    cfg.video_mul    = 32'd1;
    cfg.video_div    = 32'd1;
    cfg.audio_mul    = 32'd1;
    cfg.audio_div    = 32'd1;
    clear_segment();

    // reset settings: video on id 0, no audio path
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd5, 1, 64'd1, 1, 64'd1, 32'd1)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 1, 64'd100, 1, 64'd90, 32'd10),
                             mk_norm(8'd0, 1, 63'd10, 1, 63'd0, 32'd10, 63'd0)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 1, 64'd120, 1, 64'd95, 32'd0),
                             mk_norm(8'd0, 1, 63'd30, 1, 63'd5, 32'd0, 63'd20)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'd100, 1, 64'd92, 32'd0)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 1, 64'd80, 0, 64'd0, 32'd0),
                             mk_norm(8'd0, 1, 63'd0, 0, 63'd0, 32'd0, 63'd0)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 0, 64'd0, 0, 64'd0, 32'hFFFF_FFFF),
                             mk_norm(8'd0, 0, 63'd0, 0, 63'd0, 32'hFFFF_FFFF, 63'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'h7FFF_FFFF_FFFF_FFFF,
                                    1, 64'h8000_0000_0000_0000, 32'd3)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'hFFFF_FFFF_FFFF_FFFF,
                                    1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'hFF, 1, 64'd7, 1, 64'd7, 32'd7)));
    rows.push_back(word_row(mk_word(OP_SEGMENT, 8'd0, 1, 64'd5, 1, 64'd5, 32'd5)));
    // re-anchor with no timestamps: origin 0
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 0, 64'd0, 0, 64'd0, 32'd0),
                             mk_norm(8'd0, 0, 63'd0, 0, 63'd0, 32'd0, 63'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'hFFFF_FFFF_FFFF_FFFB,
                                    0, 64'd0, 32'd0)));
    // audio on, equal output ids, saturating video scale, zero divisor
    rows.push_back(cfg_row(REG_VIDEO_IN_ID, 32'hFF));
    rows.push_back(cfg_row(REG_AUDIO_IN_ID, 32'h0));
    rows.push_back(cfg_row(REG_VIDEO_OUT_ID, 32'hFF));
    rows.push_back(cfg_row(REG_AUDIO_OUT_ID, 32'hFF));
    rows.push_back(cfg_row(REG_VIDEO_MUL, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_VIDEO_DIV, 32'h0));
    rows.push_back(cfg_row(REG_AUDIO_MUL, 32'd3));
    rows.push_back(cfg_row(REG_AUDIO_DIV, 32'd2));
    rows.push_back(word_row(mk_word(OP_SEGMENT, 8'hFF, 0, 64'd0, 0, 64'd0, 32'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'd5, 1, 64'd5, 32'd5)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'hFF, 0, 64'd0, 0, 64'd0, 32'd0),
                             mk_norm(8'hFF, 0, 63'd0, 0, 63'd0, 32'd0, 63'd0)));
    rows.push_back(fixed_row(mk_word(OP_PACKET, 8'd0, 1, 64'd1010, 1, 64'd1000, 32'd7),
                             mk_norm(8'hFF, 1, 63'd15, 1, 63'd0, 32'd11, 63'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'hFF, 1, 64'h100_0000_0000,
                                    1, 64'h100_0000_0000, 32'd1)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'hFF, 1, 64'h100_0000_0000,
                                    1, 64'h100_0000_0000, 32'd1)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'hFF, 0, 64'd0, 0, 64'd0, 32'hFFFF_FFFF)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd0, 1, 64'd2000, 0, 64'd0, 32'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'hFF, 1, 64'h8000_0000_0000_0000,
                                    1, 64'h8000_0000_0000_0000, 32'd2)));
    // same id on both paths: video takes it
    rows.push_back(cfg_row(REG_VIDEO_IN_ID, 32'd9));
    rows.push_back(cfg_row(REG_AUDIO_IN_ID, 32'd9));
    rows.push_back(cfg_row(REG_VIDEO_OUT_ID, 32'd3));
    rows.push_back(cfg_row(REG_AUDIO_OUT_ID, 32'd4));
    rows.push_back(cfg_row(REG_VIDEO_MUL, 32'd1));
    rows.push_back(cfg_row(REG_VIDEO_DIV, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_AUDIO_MUL, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_AUDIO_DIV, 32'hFFFF_FFFF));
    rows.push_back(word_row(mk_word(OP_SEGMENT, 8'd9, 0, 64'd0, 0, 64'd0, 32'd0)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd9, 1, 64'd100, 1, 64'd100, 32'd5)));
    rows.push_back(word_row(mk_word(OP_PACKET, 8'd9, 1, 64'h7FFF_FFFF_FFFF_FFFF,
                                    1, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF)));

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          reg_write(rows[i].ridx, rows[i].rval);
        end
        default: send_word(rows[i].word, rows[i].kind == ROW_FIXED, rows[i].res, got);
      endcase
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      idle_on = (ph != 5);
      vid = $urandom_range(0, 255);
      if (ph == 2) aid = 9'h1FF;
      else if ($urandom_range(0, 7) == 0) aid = {1'b0, vid};
      else aid = {1'b0, vid + 8'($urandom_range(1, 255))};
      reg_write(REG_VIDEO_IN_ID, {24'd0, vid});
      reg_write(REG_AUDIO_IN_ID, {23'd0, aid});
      reg_write(REG_VIDEO_OUT_ID, $urandom_range(0, 255));
      reg_write(REG_AUDIO_OUT_ID, $urandom_range(0, 255));
      if (ph == 3) begin
        reg_write(REG_VIDEO_MUL, 32'hFFFF_FFFF);
        reg_write(REG_VIDEO_DIV, 32'd1);
        reg_write(REG_AUDIO_MUL, 32'd1);
        reg_write(REG_AUDIO_DIV, 32'hFFFF_FFFF);
      end else begin
        reg_write(REG_VIDEO_MUL, pick_scale(0));
        reg_write(REG_VIDEO_DIV, pick_scale(1));
        reg_write(REG_AUDIO_MUL, pick_scale(0));
        reg_write(REG_AUDIO_DIV, pick_scale(1));
      end
      ts_base = (ph == 4) ? 64'h7FFF_FFFF_FFF0_0000
                          : 64'($signed($urandom_range(0, 200000)) - 100000);
      // long receiver hold-off: the block fills up and pushes back
      if (ph == 1) hold_req = 1;
      done_cnt = 0;
      n = 0;
      while (done_cnt < PHASE_WORDS) begin
        if (ph != 5 && n % 80 == 0) idle_on = ($urandom_range(0, 3) != 0);
        n++;
        ts_base = ts_base + 64'($urandom_range(0, 3000));
        w.op = ($urandom_range(0, 99) < 2) ? OP_SEGMENT : OP_PACKET;
        case ($urandom_range(0, 19))
          0, 1:  w.sid = $urandom_range(0, 255);
          2, 3, 4, 5, 6, 7: w.sid = cfg.audio_in_id[7:0];
          default: w.sid = cfg.video_in_id;
        endcase
        w.dts = ($urandom_range(0, 9) == 0) ? ts_base - 64'($urandom_range(0, 20000))
                                            : ts_base - 64'($urandom_range(0, 50));
        w.pts = w.dts + 64'($urandom_range(0, 5000));
        if ($urandom_range(0, 19) == 0) w.pts = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0) w.dts = {$urandom, $urandom};
        if ($urandom_range(0, 49) == 0) ts_base = {$urandom, $urandom};
        w.pts_p = ($urandom_range(0, 9) != 0);
        w.dts_p = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
          0, 1, 2: w.dur = 32'd0;
          3:       w.dur = $urandom;
          default: w.dur = $urandom_range(1, 3000);
        endcase
        send_word(w, 0, none, got);
        if (got || w.op == OP_SEGMENT) done_cnt++;
        if (idle_on && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 15));
      end
    end

    wait_drained();
    if (bad_cnt == 0 && pending_stamps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
